[sv/ldhp_pkg.sv]
// ldhp_pkg: shared types and constants of the light delta huffman packer
// used by the interfaces, the code table memory, the bit buffer and the top level
package ldhp_pkg;

  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 14;
  localparam int DIFF_W      = 12;
  localparam int CODE_W      = 16;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 7;
  localparam int HEADER_BITS = 26;
  localparam int SEG_CNT_W   = 5;
  localparam int NEED_W      = 6;

  localparam int TABLE_DEPTH = 67;
  localparam logic [IDX_W-1:0] ESC_SHORT  = 7'd64;
  localparam logic [IDX_W-1:0] ESC_LONG   = 7'd65;
  localparam logic [IDX_W-1:0] STOP_ENTRY = 7'd66;
  localparam logic [IDX_W-1:0] TABLE_LAST = 7'd66;

  localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd16;
  localparam logic [3:0] RAW_SHORT_BITS = 4'd9;
  localparam logic [3:0] RAW_LONG_BITS  = 4'd11;

  localparam logic [WORD_W-1:0] SENTINEL = 32'h8000_0000;

  localparam logic [1:0] MODE_ENCODE = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_TABLE  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  typedef struct packed {
    logic shift_bit;
    logic bit_in;
    logic shift_word;
  } buf_ctrl_t;

endpackage

[sv/ldhp_ifs.sv]
// ldhp channel interfaces: item input, packed word output and configuration write
// depends on ldhp_pkg for field widths
interface ldhp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            mode;
  logic signed [ldhp_pkg::DIFF_W-1:0]    diff;
  logic [6:0]                            start_index;
  logic [16:0]                           sample_stamp;
  logic [1:0]                            day_phase;
  logic [ldhp_pkg::IDX_W-1:0]            table_index;
  logic [ldhp_pkg::CODE_W-1:0]           table_code;
  logic [ldhp_pkg::LEN_W-1:0]            table_length;

  modport source (
    output valid, mode, diff, start_index, sample_stamp, day_phase,
           table_index, table_code, table_length,
    input  ready
  );
  modport sink (
    input  valid, mode, diff, start_index, sample_stamp, day_phase,
           table_index, table_code, table_length,
    output ready
  );
endinterface

interface ldhp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ldhp_pkg::WORD_W-1:0]   word;
  logic [ldhp_pkg::ADDR_W-1:0]   word_address;
  logic                          last_word;

  modport source (output valid, word, word_address, last_word, input ready);
  modport sink (input valid, word, word_address, last_word, output ready);
endinterface

interface ldhp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ldhp_pkg::ADDR_W-1:0]   start_word_address;

  modport source (output valid, start_word_address, input ready);
  modport sink (input valid, start_word_address, output ready);
endinterface

[sv/ldhp_code_mem.sv]
// ldhp_code_mem: code and length table, one write port and one registered read port
// depends on ldhp_pkg for the entry type and table depth
module ldhp_code_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ldhp_pkg::IDX_W-1:0]    waddr,
  input  ldhp_pkg::tbl_entry_t          wdata,
  input  logic [ldhp_pkg::IDX_W-1:0]    raddr,
  output ldhp_pkg::tbl_entry_t          rdata
);

  ldhp_pkg::tbl_entry_t mem [ldhp_pkg::TABLE_DEPTH];
  ldhp_pkg::tbl_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/ldhp_bit_buffer.sv]
// ldhp_bit_buffer: pack buffer as one long shift register, one bit in per cycle
// or one 32-bit word out of the top per cycle; depends on ldhp_pkg
module ldhp_bit_buffer #(
  parameter int PACK_BITS = 256
) (
  input  logic                          clk,
  input  ldhp_pkg::buf_ctrl_t           ctrl,
  output logic [ldhp_pkg::WORD_W-1:0]   top_word
);

  logic [PACK_BITS-1:0] buf_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_word) begin
      buf_r <= {buf_r[PACK_BITS-ldhp_pkg::WORD_W-1:0], {ldhp_pkg::WORD_W{1'b0}}};
    end else if (ctrl.shift_bit) begin
      buf_r <= {buf_r[PACK_BITS-2:0], ctrl.bit_in};
    end
  end

  assign top_word = buf_r[PACK_BITS-1 -: ldhp_pkg::WORD_W];

endmodule

[sv/light_delta_huffman_packer_unit.sv]
// light_delta_huffman_packer_unit: top level of the huffman delta bit packer
// uses ldhp_pkg, the ldhp interfaces, ldhp_code_mem and ldhp_bit_buffer
//
// channels: in_if takes one item per handshake (encode a difference, store the
// stop marker or write a code table entry); out_if gives the words of a flushed
// buffer with their addresses, last_word on the final one; cfg_if writes the
// start word address, which also reloads the running write address.
// in_if.ready is high only while the sequencer is idle; one item at a time.
// a table write or an ignored mode is done at the handshake. an encode reads its
// table entry, then shifts in a new unit header when it opens one, then the code and
// the raw bits, as every header, code and raw bit goes into the buffer one per cycle.
// a flush shifts in one zero per free buffer bit (zero padding, bit serial), then
// gives its PACK_WORDS words, one word per cycle while out_if does not stall.
// the last word waits in an output register, so the next item is taken while
// it is still pending; a stalled receiver holds the flush at the current word.
// after reset the buffer is empty, no header is open and the write address is 0;
// the code table holds nothing until written.
module light_delta_huffman_packer_unit #(
  parameter int PACK_WORDS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  ldhp_in_if.sink  in_if,
  ldhp_out_if.source out_if,
  ldhp_cfg_if.sink cfg_if
);

  localparam int PACK_BITS = PACK_WORDS * ldhp_pkg::WORD_W;
  localparam int FREE_W    = $clog2(PACK_BITS + 1);
  localparam int KW        = $clog2(PACK_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DECIDE, S_PAD, S_OUT, S_HDR, S_CODE, S_RAW
  } state_t;

  state_t                          state_r;
  logic [FREE_W-1:0]               free_r;
  logic                            hdr_r;
  logic [ldhp_pkg::ADDR_W-1:0]     waddr_r;
  logic [KW-1:0]                   k_r;
  logic [ldhp_pkg::HEADER_BITS-1:0] seg_r;
  logic [ldhp_pkg::SEG_CNT_W-1:0]  cnt_r;

  logic [1:0]                      mode_r;
  logic [ldhp_pkg::DIFF_W-1:0]     diff_r;
  logic [ldhp_pkg::HEADER_BITS-1:0] header_r;

  logic                            out_valid_r;
  logic [ldhp_pkg::WORD_W-1:0]     out_word_r;
  logic [ldhp_pkg::ADDR_W-1:0]     out_addr_r;
  logic                            out_last_r;

  ldhp_pkg::buf_ctrl_t             buf_ctrl;
  logic [ldhp_pkg::WORD_W-1:0]     top_word;
  ldhp_pkg::tbl_entry_t            rd_entry;
  ldhp_pkg::tbl_entry_t            wr_entry;
  logic                            tbl_we;
  logic [ldhp_pkg::IDX_W-1:0]      rd_idx;

  logic                            in_take;
  logic                            is_enc;
  logic                            diff_small;
  logic                            diff_short;
  logic [3:0]                      extra;
  logic [ldhp_pkg::NEED_W-1:0]     need;
  logic                            out_load;
  logic                            seg_busy;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_take      = in_if.valid && in_if.ready;

  assign out_if.valid        = out_valid_r;
  assign out_if.word         = out_word_r;
  assign out_if.word_address = out_addr_r;
  assign out_if.last_word    = out_last_r;

  // table write straight from the accepted word
  assign tbl_we = in_take && (in_if.mode == ldhp_pkg::MODE_TABLE) &&
                  (in_if.table_index <= ldhp_pkg::TABLE_LAST);
  assign wr_entry.code = in_if.table_code;
  assign wr_entry.len  = (in_if.table_length > ldhp_pkg::MAX_CODE_LEN) ?
                         ldhp_pkg::MAX_CODE_LEN : in_if.table_length;

  // range classes: top bits all equal means the value fits the narrower range
  assign is_enc     = (mode_r == ldhp_pkg::MODE_ENCODE);
  assign diff_small = (diff_r[11:5] == 7'h00) || (diff_r[11:5] == 7'h7f);
  assign diff_short = (diff_r[11:8] == 4'h0) || (diff_r[11:8] == 4'hf);

  always_comb begin
    if (!is_enc) begin
      rd_idx = ldhp_pkg::STOP_ENTRY;
      extra  = 4'd0;
    end else if (diff_small) begin
      rd_idx = {1'b0, ~diff_r[5], diff_r[4:0]};
      extra  = 4'd0;
    end else if (diff_short) begin
      rd_idx = ldhp_pkg::ESC_SHORT;
      extra  = ldhp_pkg::RAW_SHORT_BITS;
    end else begin
      rd_idx = ldhp_pkg::ESC_LONG;
      extra  = ldhp_pkg::RAW_LONG_BITS;
    end
  end

  assign need = ldhp_pkg::NEED_W'(rd_entry.len) + ldhp_pkg::NEED_W'(extra) +
                (hdr_r ? '0 : ldhp_pkg::NEED_W'(ldhp_pkg::HEADER_BITS));

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);
  assign seg_busy = (cnt_r != '0);

  always_comb begin
    buf_ctrl = '0;
    case (state_r)
      S_PAD: begin
        buf_ctrl.shift_bit = (free_r != '0);
      end
      S_HDR, S_CODE, S_RAW: begin
        buf_ctrl.shift_bit = seg_busy;
        buf_ctrl.bit_in    = seg_r[cnt_r - 1'b1];
      end
      S_OUT: begin
        buf_ctrl.shift_word = out_load;
      end
      default: begin
        buf_ctrl = '0;
      end
    endcase
  end

  ldhp_code_mem u_code_mem (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_if.table_index),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  ldhp_bit_buffer #(
    .PACK_BITS (PACK_BITS)
  ) u_bit_buffer (
    .clk      (clk),
    .ctrl     (buf_ctrl),
    .top_word (top_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= FREE_W'(PACK_BITS);
      hdr_r       <= 1'b0;
      waddr_r     <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        waddr_r <= cfg_if.start_word_address;
      end
      if (out_valid_r && out_if.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            mode_r   <= in_if.mode;
            diff_r   <= in_if.diff;
            header_r <= {in_if.sample_stamp, in_if.day_phase, in_if.start_index};
            if ((in_if.mode == ldhp_pkg::MODE_ENCODE) ||
                (in_if.mode == ldhp_pkg::MODE_STOP)) begin
              state_r <= S_READ;
            end
          end
        end

        S_READ: begin
          state_r <= S_DECIDE;
        end

        S_DECIDE: begin
          if (is_enc) begin
            if (free_r < FREE_W'(need)) begin
              hdr_r <= 1'b0;
            end
            if ((free_r < FREE_W'(need)) && (free_r != FREE_W'(PACK_BITS))) begin
              state_r <= S_PAD;
            end else if ((free_r < FREE_W'(need)) || !hdr_r) begin
              seg_r   <= header_r;
              cnt_r   <= ldhp_pkg::SEG_CNT_W'(ldhp_pkg::HEADER_BITS);
              hdr_r   <= 1'b1;
              state_r <= S_HDR;
            end else begin
              seg_r   <= ldhp_pkg::HEADER_BITS'(rd_entry.code);
              cnt_r   <= rd_entry.len;
              state_r <= S_CODE;
            end
          end else begin
            // stop marker that does not fit closes the buffer and is dropped
            if (free_r < FREE_W'(rd_entry.len)) begin
              hdr_r   <= 1'b0;
              state_r <= (free_r != FREE_W'(PACK_BITS)) ? S_PAD : S_IDLE;
            end else begin
              seg_r   <= ldhp_pkg::HEADER_BITS'(rd_entry.code);
              cnt_r   <= rd_entry.len;
              state_r <= S_CODE;
            end
          end
        end

        S_PAD: begin
          if (free_r != '0) begin
            free_r <= free_r - 1'b1;
          end else begin
            k_r     <= '0;
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_word_r  <= (k_r == '0) ? (top_word | ldhp_pkg::SENTINEL) : top_word;
            out_addr_r  <= waddr_r + ldhp_pkg::ADDR_W'(k_r);
            out_last_r  <= (k_r == KW'(PACK_WORDS - 1));
            k_r         <= k_r + 1'b1;
            if (k_r == KW'(PACK_WORDS - 1)) begin
              waddr_r <= waddr_r + ldhp_pkg::ADDR_W'(PACK_WORDS);
              free_r  <= FREE_W'(PACK_BITS);
              if (is_enc) begin
                seg_r   <= header_r;
                cnt_r   <= ldhp_pkg::SEG_CNT_W'(ldhp_pkg::HEADER_BITS);
                hdr_r   <= 1'b1;
                state_r <= S_HDR;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end

        S_HDR: begin
          if (seg_busy) begin
            cnt_r  <= cnt_r - 1'b1;
            free_r <= free_r - 1'b1;
          end else begin
            seg_r   <= ldhp_pkg::HEADER_BITS'(rd_entry.code);
            cnt_r   <= rd_entry.len;
            state_r <= S_CODE;
          end
        end

        S_CODE: begin
          if (seg_busy) begin
            cnt_r  <= cnt_r - 1'b1;
            free_r <= free_r - 1'b1;
          end else if (is_enc) begin
            seg_r   <= ldhp_pkg::HEADER_BITS'(diff_r);
            cnt_r   <= ldhp_pkg::SEG_CNT_W'(extra);
            state_r <= S_RAW;
          end else begin
            state_r <= S_IDLE;
          end
        end

        S_RAW: begin
          if (seg_busy) begin
            cnt_r  <= cnt_r - 1'b1;
            free_r <= free_r - 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
